// ===== hw/rtl/prsl_pkg.sv =====
package prsl_pkg;

    localparam int unsigned RingIndexBitsDefault = 16;
    localparam int unsigned ValueBits = 32;
    localparam int unsigned WidthBits = 32;
    localparam int unsigned ThetaBits = 10;
    localparam int unsigned GradBits  = 48;
    localparam int unsigned IndexBits = 16;
    localparam int unsigned MagBits   = 47;
    localparam int unsigned DenBits   = 34;
    localparam int unsigned DivBits   = 76;
    localparam int unsigned DivSteps  = DivBits / 2;
    localparam logic [ThetaBits-1:0] ThetaReset = 10'd384;
    localparam logic [MagBits-1:0] GradCap = {MagBits{1'b1}};

    typedef logic signed [GradBits-1:0] grad_t;

    // minmod of three signed gradients; ties keep the earlier argument
    function automatic grad_t minmod3(input grad_t a, input grad_t b, input grad_t c);
        grad_t m;
        grad_t ma;
        grad_t mb;
        grad_t mc;
        m  = '0;
        ma = a[GradBits-1] ? -a : a;
        mb = b[GradBits-1] ? -b : b;
        mc = c[GradBits-1] ? -c : c;
        if (a != '0 && b != '0 && c != '0 && a[GradBits-1] == b[GradBits-1]
                && b[GradBits-1] == c[GradBits-1]) begin
            m = a;
            if (mb < ma) begin
                m  = b;
                ma = mb;
            end
            if (mc < ma) begin
                m = c;
            end
        end
        return m;
    endfunction

endpackage

// ===== hw/rtl/periodic_ring_slope_limiter_core.sv =====
// Channel   | Dir | Handshake                   | Payload
// s_        | in  | s_valid / s_ready           | cell_value, cell_width, ring_end
// m_        | out | m_valid / m_ready           | cell_index, limited_gradient, ring_done
// cfg_      | in  | cfg_valid / cfg_ready       | cfg_data (theta_limit_q8)
// Each gradient takes three divisions, one after another, on one radix-4 restoring divider;
// a request yields up to three gradients.
// Short rings and the first two cells of a ring need no division.
// Reset (aresetn low, synchronous) clears the sequencer and ring counter, theta back to 1.5.
// Results wait in the output register while m_ready is low; the sequencer holds.
module periodic_ring_slope_limiter_core
    import prsl_pkg::*;
#(
    parameter int unsigned RING_INDEX_BITS = RingIndexBitsDefault
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic signed [ValueBits-1:0] s_cell_value,
    input  logic [WidthBits-1:0]        s_cell_width,
    input  logic                        s_ring_end,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [IndexBits-1:0]        m_cell_index,
    output logic signed [GradBits-1:0]  m_limited_gradient,
    output logic                        m_ring_done,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [ThetaBits-1:0]        cfg_data
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_LOAD = 3'd1;
    localparam logic [2:0] ST_DIV  = 3'd2;
    localparam logic [2:0] ST_POST = 3'd3;
    localparam logic [2:0] ST_EMIT = 3'd4;
    localparam logic [2:0] ST_WAIT = 3'd5;
    localparam logic [RING_INDEX_BITS-1:0] CntMax = {RING_INDEX_BITS{1'b1}};

    logic [2:0] state_reg;
    logic [ThetaBits-1:0] theta_reg;
    logic [RING_INDEX_BITS-1:0] seen_reg;

    logic signed [ValueBits-1:0] fv_reg, sv_reg, ov_reg, nv_reg, cv_reg;
    logic [WidthBits-1:0] fw_reg, sw_reg, ow_reg, nw_reg, cw_reg;
    logic last_reg;

    // job: which gradient (0 older/newer/cur, 1 newer/cur/first, 2 cur/first/second)
    logic [1:0] job_reg, njobs_reg;
    logic [1:0] slope_reg;
    grad_t sa_reg, sb_reg;

    logic [DivBits-1:0] dvd_reg;
    logic [DenBits:0] rem_reg;
    logic [DenBits-1:0] den_reg;
    logic [MagBits-1:0] q_reg;
    logic sat_reg, neg_reg, zero_reg;
    logic [5:0] step_reg;

    logic [IndexBits-1:0] oidx_reg;
    grad_t ograd_reg;
    logic odone_reg, ovalid_reg;
    logic [IndexBits-1:0] nidx;
    logic [RING_INDEX_BITS-1:0] nm1;
    logic reload_zero;

    // operand selection for the current job and slope
    logic signed [ValueBits-1:0] vl, vc, vr;
    logic [WidthBits-1:0] wl, wc, wr;
    logic signed [ValueBits:0] diff;
    logic [ValueBits-1:0] dmag;
    logic [DenBits-1:0] den;
    logic [ThetaBits-1:0] fac;
    logic [ValueBits+ThetaBits-1:0] prod;
    logic [DivBits-1:0] dvd;

    always_comb begin
        vl = ov_reg; wl = ow_reg; vc = nv_reg; wc = nw_reg; vr = cv_reg; wr = cw_reg;
        case (job_reg)
            2'd1: begin
                vl = nv_reg; wl = nw_reg; vc = cv_reg; wc = cw_reg; vr = fv_reg; wr = fw_reg;
            end
            2'd2: begin
                vl = cv_reg; wl = cw_reg; vc = fv_reg; wc = fw_reg; vr = sv_reg; wr = sw_reg;
            end
            default: ;
        endcase
        case (slope_reg)
            2'd0: begin
                diff = {vc[ValueBits-1], vc} - {vl[ValueBits-1], vl};
                den  = DenBits'(wc) + DenBits'(wl);
                fac  = theta_reg;
            end
            2'd1: begin
                diff = {vr[ValueBits-1], vr} - {vl[ValueBits-1], vl};
                den  = DenBits'(wl) + {1'b0, wc, 1'b0} + DenBits'(wr);
                fac  = ThetaBits'(1);
            end
            default: begin
                diff = {vr[ValueBits-1], vr} - {vc[ValueBits-1], vc};
                den  = DenBits'(wc) + DenBits'(wr);
                fac  = theta_reg;
            end
        endcase
        dmag = diff[ValueBits] ? ValueBits'(-diff) : diff[ValueBits-1:0];
        prod = dmag * fac;
        dvd  = (slope_reg == 2'd1) ? DivBits'({prod, 37'd0}) : DivBits'({prod, 29'd0});
    end

    // radix-4 step: two restoring subtractions
    logic [DenBits:0] r1, r2, t1, t2;
    logic b1, b2;
    always_comb begin
        r1 = {rem_reg[DenBits-1:0], dvd_reg[DivBits-1]};
        b1 = r1 >= {1'b0, den_reg};
        t1 = b1 ? r1 - {1'b0, den_reg} : r1;
        r2 = {t1[DenBits-1:0], dvd_reg[DivBits-2]};
        b2 = r2 >= {1'b0, den_reg};
        t2 = b2 ? r2 - {1'b0, den_reg} : r2;
    end

    grad_t sres;
    always_comb begin
        sres = zero_reg ? '0
             : (sat_reg ? grad_t'({1'b0, GradCap}) : grad_t'({1'b0, q_reg}));
        if (neg_reg) sres = -sres;
    end

    assign s_ready   = (state_reg == ST_IDLE) && !ovalid_reg;
    assign cfg_ready = (state_reg == ST_IDLE);
    assign m_valid   = ovalid_reg;
    assign m_cell_index = oidx_reg;
    assign m_limited_gradient = ograd_reg;
    assign m_ring_done = odone_reg;
    assign nm1 = seen_reg - RING_INDEX_BITS'(1);
    // second zero result of a two-cell ring replaces the first in the same cycle
    assign reload_zero = (state_reg == ST_WAIT) && (job_reg == 2'd3);

    always_comb begin
        case (job_reg)
            2'd0:    nidx = IndexBits'(nm1);
            2'd1:    nidx = IndexBits'(seen_reg);
            default: nidx = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            theta_reg  <= ThetaReset;
            seen_reg   <= '0;
            ovalid_reg <= 1'b0;
            fv_reg <= '0; fw_reg <= '0; sv_reg <= '0; sw_reg <= '0;
            ov_reg <= '0; ow_reg <= '0; nv_reg <= '0; nw_reg <= '0;
        end else begin
            if (ovalid_reg && m_ready && !reload_zero) ovalid_reg <= 1'b0;
            if (cfg_valid && cfg_ready) theta_reg <= cfg_data;
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_valid && s_ready) begin
                        cv_reg   <= s_cell_value;
                        cw_reg   <= s_cell_width;
                        last_reg <= s_ring_end;
                        if (seen_reg == '0) begin
                            fv_reg <= s_cell_value; fw_reg <= s_cell_width;
                            if (s_ring_end) begin
                                oidx_reg <= '0; ograd_reg <= '0; odone_reg <= 1'b1;
                                ovalid_reg <= 1'b1;
                            end else begin
                                seen_reg <= RING_INDEX_BITS'(1);
                                ov_reg <= nv_reg; ow_reg <= nw_reg;
                                nv_reg <= s_cell_value; nw_reg <= s_cell_width;
                            end
                        end else if (seen_reg == RING_INDEX_BITS'(1)) begin
                            sv_reg <= s_cell_value; sw_reg <= s_cell_width;
                            if (s_ring_end) begin
                                oidx_reg <= '0; ograd_reg <= '0; odone_reg <= 1'b0;
                                ovalid_reg <= 1'b1;
                                job_reg <= 2'd3;
                                state_reg <= ST_WAIT;
                            end else begin
                                seen_reg <= RING_INDEX_BITS'(2);
                                ov_reg <= nv_reg; ow_reg <= nw_reg;
                                nv_reg <= s_cell_value; nw_reg <= s_cell_width;
                            end
                        end else begin
                            job_reg   <= 2'd0;
                            njobs_reg <= s_ring_end ? 2'd2 : 2'd0;
                            slope_reg <= 2'd0;
                            state_reg <= ST_LOAD;
                        end
                    end
                end
                ST_LOAD: begin
                    dvd_reg  <= dvd;
                    den_reg  <= den;
                    rem_reg  <= '0;
                    q_reg    <= '0;
                    sat_reg  <= 1'b0;
                    neg_reg  <= diff[ValueBits];
                    zero_reg <= (den == '0) || (diff == '0) || (fac == '0);
                    step_reg <= '0;
                    state_reg <= ST_DIV;
                end
                ST_DIV: begin
                    rem_reg <= t2;
                    dvd_reg <= {dvd_reg[DivBits-3:0], 2'b00};
                    // quotient bit positions of this step: 75-2k and 74-2k
                    if (step_reg < 6'(DivSteps - 24)) begin
                        sat_reg <= sat_reg | b1 | b2;
                    end else if (step_reg == 6'(DivSteps - 24)) begin
                        sat_reg <= sat_reg | b1;
                        q_reg   <= {q_reg[MagBits-2:0], b2};
                    end else begin
                        q_reg <= {q_reg[MagBits-3:0], b1, b2};
                    end
                    step_reg <= step_reg + 6'd1;
                    if (step_reg == 6'(DivSteps - 1)) state_reg <= ST_POST;
                end
                ST_POST: begin
                    if (slope_reg == 2'd0) begin
                        sa_reg <= sres; slope_reg <= 2'd1; state_reg <= ST_LOAD;
                    end else if (slope_reg == 2'd1) begin
                        sb_reg <= sres; slope_reg <= 2'd2; state_reg <= ST_LOAD;
                    end else begin
                        ograd_reg <= minmod3(sa_reg, sb_reg, sres);
                        oidx_reg  <= nidx;
                        odone_reg <= (job_reg == 2'd2);
                        state_reg <= ST_EMIT;
                    end
                end
                ST_EMIT: begin
                    if (!ovalid_reg || m_ready) begin
                        ovalid_reg <= 1'b1;
                        state_reg  <= ST_WAIT;
                    end
                end
                ST_WAIT: begin
                    if (m_ready) begin
                        if (job_reg == 2'd3) begin
                            // second zero gradient of a two-cell ring
                            oidx_reg <= IndexBits'(1); ograd_reg <= '0; odone_reg <= 1'b1;
                            ovalid_reg <= 1'b1;
                            seen_reg <= '0;
                            state_reg <= ST_IDLE;
                        end else if (job_reg < njobs_reg) begin
                            job_reg <= job_reg + 2'd1;
                            slope_reg <= 2'd0;
                            state_reg <= ST_LOAD;
                        end else begin
                            if (last_reg) begin
                                seen_reg <= '0;
                            end else begin
                                if (seen_reg != CntMax) seen_reg <= seen_reg + RING_INDEX_BITS'(1);
                            end
                            ov_reg <= nv_reg; ow_reg <= nw_reg;
                            nv_reg <= cv_reg; nw_reg <= cw_reg;
                            state_reg <= ST_IDLE;
                        end
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_IDLE) |-> !s_ready) else $error("accept while busy");
    a_div_len: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DIV) |-> (step_reg < 6'(DivSteps))) else $error("divider overrun");
    a_emit_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> m_valid) else $error("result dropped");

endmodule

// ===== tb/tb_periodic_ring_slope_limiter_core.sv =====
module tb_periodic_ring_slope_limiter_core;
    import prsl_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CycleLimit = 1000000;
    localparam int DrainCycles = 400;
    localparam int PhaseItems = 50;

    typedef struct packed {
        logic [IndexBits-1:0] idx;
        grad_t                grad;
        logic                 done;
    } grad_rec_t;

    typedef struct packed {
        logic signed [ValueBits-1:0] value;
        logic [WidthBits-1:0]        width;
        logic                        last;
        logic                        zero_grad;  // gradients known to be zero
    } cell_row_t;

    logic                        aclk;
    logic                        aresetn;
    logic                        s_valid;
    logic                        s_ready;
    logic signed [ValueBits-1:0] s_cell_value;
    logic [WidthBits-1:0]        s_cell_width;
    logic                        s_ring_end;
    logic                        m_valid;
    logic                        m_ready;
    logic [IndexBits-1:0]        m_cell_index;
    logic signed [GradBits-1:0]  m_limited_gradient;
    logic                        m_ring_done;
    logic                        cfg_valid;
    logic                        cfg_ready;
    logic [ThetaBits-1:0]        cfg_data;

    periodic_ring_slope_limiter_core u_top (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_cell_value      (s_cell_value),
        .s_cell_width      (s_cell_width),
        .s_ring_end        (s_ring_end),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_cell_index      (m_cell_index),
        .m_limited_gradient(m_limited_gradient),
        .m_ring_done       (m_ring_done),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_data          (cfg_data)
    );

    always begin
        aclk = 1'b1;
        #5;
        aclk = 1'b0;
        #5;
    end

    // shadow of the ring state
    logic [ThetaBits-1:0]        theta_q8;
    logic signed [ValueBits-1:0] cell0_val, cell1_val, back2_val, back1_val;
    logic [WidthBits-1:0]        cell0_wid, cell1_wid, back2_wid, back1_wid;
    logic [IndexBits-1:0]        ring_count;

    grad_rec_t grad_queue[$];
    int        errors;
    int        burst_left;
    int        phase_items;
    logic signed [ValueBits-1:0] ring_base;

    task automatic report(input string what);
        $display("mismatch: %s", what);
        errors++;
    endtask

    function automatic grad_t ring_slope(input longint diff, input int unsigned factor,
                                         input int unsigned shift, input logic [63:0] den);
        logic [127:0] num;
        logic [127:0] quo;
        logic [63:0]  mag;
        if (den == 0 || diff == 0 || factor == 0) begin
            return '0;
        end
        mag = diff < 0 ? 64'(-diff) : 64'(diff);
        num = ({64'd0, mag} * 128'(factor)) << shift;
        quo = num / {64'd0, den};
        if (quo > 128'(GradCap)) begin
            quo = 128'(GradCap);
        end
        return diff < 0 ? -grad_t'(quo[GradBits-1:0]) : grad_t'(quo[GradBits-1:0]);
    endfunction

    function automatic grad_t limit3(input grad_t a, input grad_t b, input grad_t c);
        grad_t pick;
        longint ma, mb, mc;
        ma = a < 0 ? -longint'(a) : longint'(a);
        mb = b < 0 ? -longint'(b) : longint'(b);
        mc = c < 0 ? -longint'(c) : longint'(c);
        if (a == 0 || b == 0 || c == 0) begin
            return '0;
        end
        if ((a < 0) != (b < 0) || (b < 0) != (c < 0)) begin
            return '0;
        end
        pick = a;
        if (mb < ma) begin
            pick = b;
            ma = mb;
        end
        if (mc < ma) begin
            pick = c;
        end
        return pick;
    endfunction

    function automatic grad_t cell_gradient(
            input logic signed [ValueBits-1:0] vl, input logic [WidthBits-1:0] wl,
            input logic signed [ValueBits-1:0] vc, input logic [WidthBits-1:0] wc,
            input logic signed [ValueBits-1:0] vr, input logic [WidthBits-1:0] wr);
        grad_t lft, ctr, rgt;
        lft = ring_slope(longint'(vc) - longint'(vl), theta_q8, 29,
                         64'(wc) + 64'(wl));
        ctr = ring_slope(longint'(vr) - longint'(vl), 1, 37,
                         64'(wl) + 2 * 64'(wc) + 64'(wr));
        rgt = ring_slope(longint'(vr) - longint'(vc), theta_q8, 29,
                         64'(wc) + 64'(wr));
        return limit3(lft, ctr, rgt);
    endfunction

    task automatic expect_grad(input logic [IndexBits-1:0] idx, input grad_t g,
                               input logic done, input logic zero_grad);
        grad_rec_t r;
        r.idx = idx;
        r.grad = zero_grad ? 48'sd0 : g;
        r.done = done;
        grad_queue.push_back(r);
    endtask

    task automatic predict_cell(input logic signed [ValueBits-1:0] v,
                                input logic [WidthBits-1:0] w, input logic last,
                                input logic zero_grad);
        if (ring_count == 0) begin
            cell0_val = v;
            cell0_wid = w;
            if (last) begin
                expect_grad('0, '0, 1'b1, 1'b1);
                return;
            end
        end else if (ring_count == 1) begin
            cell1_val = v;
            cell1_wid = w;
            if (last) begin
                expect_grad('0, '0, 1'b0, 1'b1);
                expect_grad(IndexBits'(1), '0, 1'b1, 1'b1);
                ring_count = 0;
                return;
            end
        end else begin
            expect_grad(ring_count - 1'b1,
                        cell_gradient(back2_val, back2_wid, back1_val, back1_wid, v, w),
                        1'b0, zero_grad);
            if (last) begin
                expect_grad(ring_count,
                            cell_gradient(back1_val, back1_wid, v, w, cell0_val, cell0_wid),
                            1'b0, zero_grad);
                expect_grad('0,
                            cell_gradient(v, w, cell0_val, cell0_wid, cell1_val, cell1_wid),
                            1'b1, zero_grad);
                ring_count = 0;
                return;
            end
        end
        back2_val = back1_val;
        back2_wid = back1_wid;
        back1_val = v;
        back1_wid = w;
        if (ring_count != '1) begin
            ring_count++;
        end
    endtask

    // called at a falling edge; returns at a falling edge after acceptance
    task automatic send_cell(input cell_row_t row);
        s_valid = 1'b1;
        s_cell_value = row.value;
        s_cell_width = row.width;
        s_ring_end = row.last;
        do begin
            @(posedge aclk);
        end while (!s_ready);
        predict_cell(row.value, row.width, row.last, row.zero_grad);
        phase_items++;
        @(negedge aclk);
        if (burst_left == 0) begin
            s_valid = 1'b0;
            repeat ($urandom_range(1, 12)) @(negedge aclk);
            burst_left = $urandom_range(0, 3) == 0 ? $urandom_range(20, 40)
                                                   : $urandom_range(0, 8);
        end else begin
            burst_left--;
        end
    endtask

    task automatic wait_idle();
        s_valid = 1'b0;
        while (grad_queue.size() != 0) @(posedge aclk);
        repeat (DrainCycles) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic write_theta(input logic [ThetaBits-1:0] val);
        cfg_valid = 1'b1;
        cfg_data = val;
        do begin
            @(posedge aclk);
        end while (!cfg_ready);
        theta_q8 = val;
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    function automatic logic signed [ValueBits-1:0] rand_value();
        case ($urandom_range(0, 9))
            0: return 32'sh8000_0000;
            1: return 32'sh7FFF_FFFF;
            2, 3: return $urandom;
            default: return ring_base + $signed($urandom_range(0, 32'h3_0000)) - 32'sh1_8000;
        endcase
    endfunction

    function automatic logic [WidthBits-1:0] rand_width();
        case ($urandom_range(0, 7))
            0: return 32'd1;
            1: return 32'hFFFF_FFFF;
            2: return $urandom_range(1, 32'hFFFF_FFFF);
            default: return 32'h1000_0000 + $urandom_range(0, 32'h0FFF_FFFF) - 32'h0800_0000;
        endcase
    endfunction

    task automatic send_random_ring();
        int len;
        cell_row_t row;
        case ($urandom_range(0, 9))
            0: len = 1;
            1: len = 2;
            9: len = $urandom_range(9, 24);
            default: len = $urandom_range(3, 8);
        endcase
        ring_base = $urandom;
        for (int i = 0; i < len; i++) begin
            row.value = rand_value();
            row.width = rand_width();
            row.last = (i == len - 1);
            row.zero_grad = 1'b0;
            send_cell(row);
        end
    endtask

    cell_row_t directed_cells[19] = '{
        '{32'sd5, 32'h1000_0000, 1'b1, 1'b1},
        '{32'sh7FFF_FFFF, 32'hFFFF_FFFF, 1'b0, 1'b1},
        '{32'sh8000_0000, 32'd1, 1'b1, 1'b1},
        '{32'sh8000_0000, 32'd1, 1'b0, 1'b0},
        '{32'sh7FFF_FFFF, 32'd1, 1'b0, 1'b0},
        '{32'sh8000_0000, 32'hFFFF_FFFF, 1'b1, 1'b0},
        '{32'sh0003_0000, 32'h1000_0000, 1'b0, 1'b1},
        '{32'sh0003_0000, 32'h2000_0000, 1'b0, 1'b1},
        '{32'sh0003_0000, 32'd1, 1'b0, 1'b1},
        '{32'sh0003_0000, 32'hFFFF_FFFF, 1'b1, 1'b1},
        '{32'sh0000_0000, 32'h1000_0000, 1'b0, 1'b0},
        '{32'sh0001_0000, 32'h1000_0000, 1'b0, 1'b0},
        '{32'sh0002_0000, 32'h1000_0000, 1'b0, 1'b0},
        '{32'sh0003_0000, 32'h0800_0000, 1'b0, 1'b0},
        '{32'sh0004_0000, 32'h1800_0000, 1'b1, 1'b0},
        '{32'shFFFF_0000, 32'h1000_0000, 1'b0, 1'b0},
        '{32'sh0001_0000, 32'h1000_0000, 1'b0, 1'b0},
        '{32'shFFFF_0000, 32'h1000_0000, 1'b0, 1'b0},
        '{32'sh0001_0000, 32'h1000_0000, 1'b1, 1'b0}
    };

    // result checker
    always @(posedge aclk) begin
        grad_rec_t want;
        if (aresetn && m_valid && m_ready) begin
            if (grad_queue.size() == 0) begin
                report($sformatf("unexpected gradient idx %0d", m_cell_index));
            end else begin
                want = grad_queue.pop_front();
                if (m_cell_index !== want.idx)
                    report($sformatf("cell_index %0d, want %0d", m_cell_index, want.idx));
                if (m_limited_gradient !== want.grad)
                    report($sformatf("gradient %0d, want %0d (idx %0d)",
                                     m_limited_gradient, want.grad, want.idx));
                if (m_ring_done !== want.done)
                    report($sformatf("ring_done %0b, want %0b (idx %0d)",
                                     m_ring_done, want.done, want.idx));
            end
        end
    end

    // receiver stall pattern: one of four modes, redrawn at random
    initial begin
        int mode;
        int tick;
        m_ready = 1'b0;
        tick = 0;
        mode = 0;
        forever begin
            @(negedge aclk);
            if (tick % 300 == 0) mode = $urandom_range(0, 3);
            case (mode)
                0: m_ready = 1'b1;
                1: m_ready = 1'($urandom_range(0, 1));
                2: m_ready = (tick % 8) < 3;
                default: m_ready = (tick % 64) >= 50;
            endcase
            tick++;
        end
    end

    initial begin
        repeat (CycleLimit) @(posedge aclk);
        $display("[FAIL] regression broken");
        $finish;
    end

    initial begin
        logic [ThetaBits-1:0] theta_plan[6];
        theta_plan = '{ThetaReset, 10'd256, 10'd512, 10'd0, 10'd1023, 10'd0};
        theta_plan[5] = ThetaBits'($urandom_range(256, 512));
        errors = 0;
        burst_left = 0;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_cell_value = '0;
        s_cell_width = '0;
        s_ring_end = 1'b0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        theta_q8 = ThetaReset;
        cell0_val = '0; cell1_val = '0; back2_val = '0; back1_val = '0;
        cell0_wid = '0; cell1_wid = '0; back2_wid = '0; back1_wid = '0;
        ring_count = '0;
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        for (int ph = 0; ph < 6; ph++) begin
            phase_items = 0;
            if (ph > 0) begin
                wait_idle();
                write_theta(theta_plan[ph]);
            end
            if (ph == 0) begin
                foreach (directed_cells[i]) send_cell(directed_cells[i]);
            end
            while (phase_items < PhaseItems) begin
                send_random_ring();
                // early in phase 2, sender holds off until requests drain
                if (ph == 2 && phase_items < 12) begin
                    s_valid = 1'b0;
                    while (grad_queue.size() != 0) @(posedge aclk);
                    @(negedge aclk);
                end
            end
        end
        s_valid = 1'b0;
        while (grad_queue.size() != 0) @(posedge aclk);
        repeat (DrainCycles) @(posedge aclk);

        if (errors == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
hw/rtl/prsl_pkg.sv
hw/rtl/periodic_ring_slope_limiter_core.sv
tb/tb_periodic_ring_slope_limiter_core.sv
